// ===== hdl/assert_macros.svh =====
// Assertion macros for the latency histogram unit.
// Included by the histogram top level, which carries the concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LHP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("histogram assertion failed");
`define LHP_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("histogram forbidden condition seen");
`else
`define LHP_ASSERT(lbl, clk, rst_n, prop)
`define LHP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/lhp_pkg.sv =====
// Shared types, codes and constants of the log2 latency histogram unit.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps

package lhp_pkg;

  localparam int BUCKETS_DEF    = 64;
  localparam int COUNT_BITS_DEF = 32;

  localparam int LAT_W   = 64;
  localparam int TOTAL_W = 38;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = 45;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MSB_W   = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;

  localparam logic [PCT_W-1:0] PCT_LOW_RST  = 7'd50;
  localparam logic [PCT_W-1:0] PCT_MID_RST  = 7'd90;
  localparam logic [PCT_W-1:0] PCT_HIGH_RST = 7'd99;

  localparam logic [OP_W-1:0] OP_RECORD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SNAPSHOT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PCT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PROD,
    ST_EST,
    ST_DONE
  } state_t;

  // Position of the highest set bit, zero for a zero value.
  function automatic logic [MSB_W-1:0] msb_index(input logic [LAT_W-1:0] v);
    logic [MSB_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < LAT_W; i++) begin
      if (v[i]) begin
        idx = MSB_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] p);
    return (p > PCT_FULL) ? PCT_FULL : p;
  endfunction

endpackage

// ===== hdl/lhp_bucket_ram.sv =====
// Bucket counter memory: one write port, one registered read port, per-entry valid bits.
// Depends on nothing but its parameters; instantiated by the histogram top level.
`timescale 1ns / 1ps

module lhp_bucket_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
    rd_vld_r  <= vld_r[raddr];
  end

  // Entries that were never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hdl/log2_latency_histogram_percentiles_unit.sv =====
// Top level of the log2 latency histogram with three percentile estimates.
// Depends on lhp_pkg, lhp_bucket_ram and assert_macros.svh.
// Record and clear items are taken one per cycle unless stalled; a record updates its counter in the
// next cycle. A snapshot walks the buckets twice, one per cycle, to sum them and find the estimates;
// it stalls input until its result is loaded, longer while an earlier result still waits.
// Synchronous reset empties all buckets and the maximum and restores 50/90/99 percent.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module log2_latency_histogram_percentiles_unit #(
  parameter int BUCKETS    = lhp_pkg::BUCKETS_DEF,
  parameter int COUNT_BITS = lhp_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lhp_pkg::OP_W-1:0]         in_operation,
  input  logic [lhp_pkg::LAT_W-1:0]        in_latency,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lhp_pkg::TOTAL_W-1:0]      out_sample_count,
  output logic [lhp_pkg::LAT_W-1:0]        out_max_latency,
  output logic [lhp_pkg::LAT_W-1:0]        out_est_low,
  output logic [lhp_pkg::LAT_W-1:0]        out_est_mid,
  output logic [lhp_pkg::LAT_W-1:0]        out_est_high,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lhp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lhp_pkg::PCT_W-1:0]        cfg_data
);

  localparam int LOG2B = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CNT_W = LOG2B + 1;
  localparam int ACC_W = ((COUNT_BITS > lhp_pkg::TOTAL_W) ? COUNT_BITS : lhp_pkg::TOTAL_W) + 1;
  localparam int NPCT  = 3;

  lhp_pkg::state_t state_r, state_nxt;

  logic [lhp_pkg::PCT_W-1:0] pct_r [NPCT];

  logic                  in_acc;
  logic                  rec_acc;
  logic                  snap_acc;
  logic                  clr_acc;
  logic [LOG2B-1:0]      in_bkt;
  logic [lhp_pkg::MSB_W:0] in_msb;

  logic                  s1_valid_r;
  logic [LOG2B-1:0]      s1_idx_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_val_r;
  logic [COUNT_BITS-1:0] s1_old;
  logic [COUNT_BITS-1:0] s1_new;

  logic [lhp_pkg::LAT_W-1:0] max_r;

  logic [LOG2B-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic [CNT_W-1:0]      cnt_r;
  logic                  rd_pend_r;
  logic [LOG2B-1:0]      rd_idx_r;
  logic                  walk_issue;
  logic                  walk_end;
  logic                  walk_start;
  logic                  sum_done;
  logic                  prod_go;
  logic                  load_out;

  logic [lhp_pkg::TOTAL_W-1:0] cum_r;
  logic [lhp_pkg::TOTAL_W-1:0] total_r;
  logic [ACC_W-1:0]            acc_sum;
  logic [lhp_pkg::TOTAL_W-1:0] cum_step;
  logic [lhp_pkg::PROD_W-1:0]  cum_scaled;

  logic [lhp_pkg::PROD_W-1:0]  prod_r [NPCT];
  logic [NPCT-1:0]             hit_r;
  logic [LOG2B-1:0]            est_idx_r [NPCT];
  logic [NPCT-1:0]             lane_hit;

  logic                        out_valid_r;
  logic [lhp_pkg::TOTAL_W-1:0] out_count_r;
  logic [lhp_pkg::LAT_W-1:0]   out_max_r;
  logic [lhp_pkg::LAT_W-1:0]   out_est_r [NPCT];

  // Input side.
  assign in_stall = (state_r != lhp_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rec_acc  = in_acc && (in_operation == lhp_pkg::OP_RECORD);
  assign snap_acc = in_acc && (in_operation == lhp_pkg::OP_SNAPSHOT);
  assign clr_acc  = in_acc && (in_operation == lhp_pkg::OP_CLEAR);

  assign in_msb = {1'b0, lhp_pkg::msb_index(in_latency)};
  assign in_bkt = (in_msb > (lhp_pkg::MSB_W + 1)'(BUCKETS - 1)) ?
                  LOG2B'(BUCKETS - 1) : LOG2B'(in_msb);

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r[0] <= lhp_pkg::PCT_LOW_RST;
      pct_r[1] <= lhp_pkg::PCT_MID_RST;
      pct_r[2] <= lhp_pkg::PCT_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lhp_pkg::CFG_PCT_LOW:  pct_r[0] <= cfg_data;
        lhp_pkg::CFG_PCT_MID:  pct_r[1] <= cfg_data;
        lhp_pkg::CFG_PCT_HIGH: pct_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Record path: read at accept, increment and write back in the next cycle.
  assign s1_old = fwd_hit_r ? fwd_val_r : ram_rdata;
  assign s1_new = (&s1_old) ? s1_old : s1_old + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      max_r      <= '0;
    end else begin
      s1_valid_r <= rec_acc;
      fwd_hit_r  <= rec_acc && s1_valid_r && (in_bkt == s1_idx_r);
      if (clr_acc) begin
        max_r <= '0;
      end else if (rec_acc && (in_latency > max_r)) begin
        max_r <= in_latency;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= in_bkt;
    fwd_val_r <= s1_new;
  end

  assign ram_raddr = (state_r == lhp_pkg::ST_IDLE) ? in_bkt : cnt_r[LOG2B-1:0];

  lhp_bucket_ram #(
    .DEPTH (BUCKETS),
    .WIDTH (COUNT_BITS),
    .AW    (LOG2B)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr_acc),
    .we    (s1_valid_r),
    .waddr (s1_idx_r),
    .wdata (s1_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Snapshot walks.
  assign acc_sum    = ACC_W'(cum_r) + ACC_W'(ram_rdata);
  assign cum_step   = (acc_sum > ACC_W'(lhp_pkg::TOTAL_MAX)) ?
                      lhp_pkg::TOTAL_MAX : acc_sum[lhp_pkg::TOTAL_W-1:0];
  assign cum_scaled = lhp_pkg::PROD_W'(cum_step) * lhp_pkg::PROD_W'(lhp_pkg::PCT_FULL) +
                      lhp_pkg::PROD_W'(lhp_pkg::PCT_FULL - 7'd1);

  always_comb begin
    for (int k = 0; k < NPCT; k++) begin
      lane_hit[k] = (cum_step != '0) && (cum_scaled >= prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lhp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    walk_issue = 1'b0;
    walk_end   = 1'b0;
    walk_start = 1'b0;
    sum_done   = 1'b0;
    prod_go    = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      lhp_pkg::ST_IDLE: begin
        if (snap_acc) begin
          walk_start = 1'b1;
          state_nxt  = lhp_pkg::ST_SUM;
        end
      end
      lhp_pkg::ST_SUM: begin
        walk_issue = (cnt_r != CNT_W'(BUCKETS));
        walk_end   = !walk_issue && !rd_pend_r;
        if (walk_end) begin
          sum_done  = 1'b1;
          state_nxt = lhp_pkg::ST_PROD;
        end
      end
      lhp_pkg::ST_PROD: begin
        prod_go    = 1'b1;
        walk_start = 1'b1;
        state_nxt  = lhp_pkg::ST_EST;
      end
      lhp_pkg::ST_EST: begin
        walk_issue = (cnt_r != CNT_W'(BUCKETS));
        walk_end   = !walk_issue && !rd_pend_r;
        if (walk_end) begin
          state_nxt = lhp_pkg::ST_DONE;
        end
      end
      lhp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = lhp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lhp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
    end else if (walk_start) begin
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= walk_issue;
      if (walk_issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[LOG2B-1:0];
    if (walk_start) begin
      cum_r <= '0;
    end else if (rd_pend_r) begin
      cum_r <= cum_step;
    end
    if (sum_done) begin
      total_r <= cum_r;
    end
    for (int k = 0; k < NPCT; k++) begin
      if (prod_go) begin
        prod_r[k] <= lhp_pkg::PROD_W'(total_r) *
                     lhp_pkg::PROD_W'(lhp_pkg::pct_clamp(pct_r[k]));
        hit_r[k]     <= 1'b0;
        est_idx_r[k] <= LOG2B'(BUCKETS - 1);
      end else if ((state_r == lhp_pkg::ST_EST) && rd_pend_r && !hit_r[k] && lane_hit[k]) begin
        hit_r[k]     <= 1'b1;
        est_idx_r[k] <= rd_idx_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count_r <= total_r;
      out_max_r   <= max_r;
      for (int k = 0; k < NPCT; k++) begin
        out_est_r[k] <= (total_r == '0) ? '0 :
                        (lhp_pkg::LAT_W'(1) << est_idx_r[k]);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_count = out_count_r;
  assign out_max_latency  = out_max_r;
  assign out_est_low      = out_est_r[0];
  assign out_est_mid      = out_est_r[1];
  assign out_est_high     = out_est_r[2];

  `LHP_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == lhp_pkg::ST_DONE))
  `LHP_ASSERT(a_fwd_needs_s1, clk, rst_n, fwd_hit_r |-> s1_valid_r)
  `LHP_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(BUCKETS))
  `LHP_ASSERT(a_empty_zero_est, clk, rst_n,
    (out_valid_r && (out_count_r == '0)) |->
    ((out_est_r[0] == '0) && (out_est_r[1] == '0) && (out_est_r[2] == '0)))
  `LHP_ASSERT(a_s1_from_idle, clk, rst_n, s1_valid_r |-> $past(state_r == lhp_pkg::ST_IDLE))

endmodule
